// ===== design/assert_macros.svh =====
// assertion shorthands used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, reset included
`define CBS_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("cbs assertion failed");

// property checked only while out of reset
`define CBS_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cbs assertion failed");

`endif

// ===== design/cbs_pkg.sv =====
package cbs_pkg;

  localparam int unsigned SizeW = 32;
  localparam int unsigned CntW  = 64;

  typedef enum logic [2:0] {
    CMD_ADD         = 3'd0,
    CMD_HOLE        = 3'd1,
    CMD_REDACTED    = 3'd2,
    CMD_ERROR       = 3'd3,
    CMD_READ_BIN    = 3'd4,
    CMD_READ_TOTALS = 3'd5
  } cmd_e;

  // decoded word handed from the front to the back
  typedef struct packed {
    cmd_e             cmd;
    logic [SizeW-1:0] logical_size;
    logic [SizeW-1:0] physical_size;
    logic [SizeW-1:0] allocated_size;
    logic             is_embedded;
    logic             unknown;
  } op_t;

  // the six sums kept per bin and for the totals
  typedef struct packed {
    logic [CntW-1:0] blocks;
    logic [CntW-1:0] logical;
    logic [CntW-1:0] physical;
    logic [CntW-1:0] allocated;
    logic [CntW-1:0] emb_blocks;
    logic [CntW-1:0] emb_logical;
  } sums_t;

  typedef struct packed {
    logic [CntW-1:0] holes;
    logic [CntW-1:0] redacted;
    logic [CntW-1:0] errors;
    logic [CntW-1:0] unknown;
  } events_t;

  localparam int unsigned SumsW = $bits(sums_t);

  function automatic sums_t sums_add(sums_t a, sums_t b);
    sums_t r;
    r.blocks      = a.blocks + b.blocks;
    r.logical     = a.logical + b.logical;
    r.physical    = a.physical + b.physical;
    r.allocated   = a.allocated + b.allocated;
    r.emb_blocks  = a.emb_blocks + b.emb_blocks;
    r.emb_logical = a.emb_logical + b.emb_logical;
    return r;
  endfunction

endpackage

// ===== design/cbs_if.sv =====
interface cbs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  comp_code;
  logic [31:0] logical_size;
  logic [31:0] physical_size;
  logic [31:0] allocated_size;
  logic        is_embedded;

  modport source (
    output valid, command, comp_code, logical_size, physical_size, allocated_size,
           is_embedded,
    input  ready
  );
  modport sink (
    input  valid, command, comp_code, logical_size, physical_size, allocated_size,
           is_embedded,
    output ready
  );
endinterface

interface cbs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_count;
  logic [63:0] logical_sum;
  logic [63:0] physical_sum;
  logic [63:0] allocated_sum;
  logic [63:0] embedded_count;
  logic [63:0] embedded_logical_sum;
  logic [63:0] hole_count;
  logic [63:0] redacted_count;
  logic [63:0] error_count;
  logic [63:0] unknown_count;
  logic        record_is_total;

  modport source (
    output valid, block_count, logical_sum, physical_sum, allocated_sum, embedded_count,
           embedded_logical_sum, hole_count, redacted_count, error_count, unknown_count,
           record_is_total,
    input  ready
  );
  modport sink (
    input  valid, block_count, logical_sum, physical_sum, allocated_sum, embedded_count,
           embedded_logical_sum, hole_count, redacted_count, error_count, unknown_count,
           record_is_total,
    output ready
  );
endinterface

// ===== design/compression_bin_statistics.sv =====
// Per-bin compression statistics counters.
// Input channel in_i takes one word per command: add block, hole, redacted,
// traversal error, read bin or read totals; undefined commands are taken and
// dropped without a result. Output channel out_o returns one word per defined
// command: the six sums of the addressed bin (add block, read bin) or of the
// totals, the four event counters, and record_is_total.
// A result passes through the queue, the back end's operation register and the
// output register before it shows on out_o, once that register is free.
// The back end takes a new word only once the last one's result is registered,
// after the bin memory's registered read and its write-back.
// A two-word queue after the decoder takes words while the back end works; in_i
// ready drops only when that queue is full.
// Reset clears totals, event counters and the per-bin valid flags at once; a bin
// with its flag clear reads as zero, so no clearing pass runs.
// When the receiver stalls the result holds on out_o, the back end waits, the
// queue fills and then in_i ready falls.
module compression_bin_statistics #(
  parameter int unsigned NUM_CODES = 17
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbs_in_if.sink    in_i,
  cbs_out_if.source out_o
);

  localparam int unsigned BinW = $clog2(NUM_CODES);

  logic            op_valid, op_pop;
  cbs_pkg::op_t    op;
  logic [BinW-1:0] bin;

  logic                       rd_en, wr_en;
  logic [BinW-1:0]            rd_addr, wr_addr;
  logic [cbs_pkg::SumsW-1:0]  rdata, wdata;

  cbs_front #(.NUM_CODES(NUM_CODES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .bin_o      (bin),
    .op_pop_i   (op_pop)
  );

  cbs_back #(.NUM_CODES(NUM_CODES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (op_valid),
    .op_i          (op),
    .bin_i         (bin),
    .op_pop_o      (op_pop),
    .ram_rd_en_o   (rd_en),
    .ram_rd_addr_o (rd_addr),
    .ram_rdata_i   (rdata),
    .ram_wr_en_o   (wr_en),
    .ram_wr_addr_o (wr_addr),
    .ram_wdata_o   (wdata),
    .out_o         (out_o)
  );

  cbs_ram #(.Width(cbs_pkg::SumsW), .Depth(NUM_CODES)) u_bins (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wdata_i   (wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rdata_o   (rdata)
  );

endmodule

// ===== design/cbs_ram.sv =====
module cbs_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cbs_front.sv =====
module cbs_front #(
  parameter  int unsigned NUM_CODES = 17,
  localparam int unsigned BinW      = $clog2(NUM_CODES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cbs_in_if.sink          in_i,
  output logic            op_valid_o,
  output cbs_pkg::op_t    op_o,
  output logic [BinW-1:0] bin_o,
  input  logic            op_pop_i
);

  localparam logic [7:0] CodeLimit = 8'(NUM_CODES);
  localparam logic [1:0] QFull     = 2'd2;

  logic         legal;
  logic         push;
  cbs_pkg::op_t op_new;
  logic [BinW-1:0] bin_new;

  cbs_pkg::op_t    op_q  [2];
  logic [BinW-1:0] bin_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q, count_d;

  assign legal = (in_i.command inside {cbs_pkg::CMD_ADD, cbs_pkg::CMD_HOLE,
                                       cbs_pkg::CMD_REDACTED, cbs_pkg::CMD_ERROR,
                                       cbs_pkg::CMD_READ_BIN, cbs_pkg::CMD_READ_TOTALS});

  // out-of-range codes fold into bin 0
  always_comb begin
    op_new.cmd            = cbs_pkg::cmd_e'(in_i.command);
    op_new.logical_size   = in_i.logical_size;
    op_new.physical_size  = in_i.physical_size;
    op_new.allocated_size = in_i.allocated_size;
    op_new.is_embedded    = in_i.is_embedded;
    op_new.unknown        = (in_i.comp_code >= CodeLimit);
    bin_new               = op_new.unknown ? '0 : in_i.comp_code[BinW-1:0];
  end

  assign in_i.ready = (count_q != QFull);
  // undefined commands are taken and dropped here
  assign push       = in_i.valid && in_i.ready && legal;

  always_comb begin
    count_d = count_q;
    case ({push, op_pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (op_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= op_new;
      bin_q[wr_ptr_q] <= bin_new;
    end
  end

  assign op_valid_o = (count_q != 2'd0);
  assign op_o       = op_q[rd_ptr_q];
  assign bin_o      = bin_q[rd_ptr_q];

endmodule

// ===== design/cbs_back.sv =====
module cbs_back #(
  parameter  int unsigned NUM_CODES = 17,
  localparam int unsigned BinW      = $clog2(NUM_CODES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_valid_i,
  input  cbs_pkg::op_t    op_i,
  input  logic [BinW-1:0] bin_i,
  output logic            op_pop_o,
  output logic            ram_rd_en_o,
  output logic [BinW-1:0] ram_rd_addr_o,
  input  cbs_pkg::sums_t  ram_rdata_i,
  output logic            ram_wr_en_o,
  output logic [BinW-1:0] ram_wr_addr_o,
  output cbs_pkg::sums_t  ram_wdata_o,
  cbs_out_if.source       out_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  cbs_pkg::op_t    op_q;
  logic [BinW-1:0] bin_q;
  logic [NUM_CODES-1:0] bin_valid_q;
  cbs_pkg::sums_t  tot_q;
  cbs_pkg::events_t evt_q, evt_new;

  logic             out_valid_q;
  cbs_pkg::sums_t   out_sums_q, out_sums_d;
  cbs_pkg::events_t out_evt_q;
  logic             out_total_q, out_total_d;

  logic            pop, fire, is_add;
  cbs_pkg::sums_t  bin_cur, bin_new, tot_new, inc;

  assign pop    = (state_q == S_IDLE) && op_valid_i;
  assign fire   = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);
  assign is_add = (op_q.cmd == cbs_pkg::CMD_ADD);

  // an entry never written reads as zero
  assign bin_cur = bin_valid_q[bin_q] ? ram_rdata_i : '0;

  always_comb begin
    inc.blocks      = 64'd1;
    inc.logical     = 64'(op_q.logical_size);
    inc.physical    = 64'(op_q.physical_size);
    inc.allocated   = 64'(op_q.allocated_size);
    inc.emb_blocks  = {63'd0, op_q.is_embedded};
    inc.emb_logical = op_q.is_embedded ? 64'(op_q.logical_size) : 64'd0;
  end

  assign bin_new = cbs_pkg::sums_add(bin_cur, inc);
  assign tot_new = cbs_pkg::sums_add(tot_q, inc);

  always_comb begin
    evt_new     = evt_q;
    out_sums_d  = tot_q;
    out_total_d = 1'b1;
    case (op_q.cmd)
      cbs_pkg::CMD_ADD: begin
        if (op_q.unknown) begin
          evt_new.unknown = evt_q.unknown + 64'd1;
        end
        out_sums_d  = bin_new;
        out_total_d = 1'b0;
      end
      cbs_pkg::CMD_HOLE:     evt_new.holes    = evt_q.holes + 64'd1;
      cbs_pkg::CMD_REDACTED: evt_new.redacted = evt_q.redacted + 64'd1;
      cbs_pkg::CMD_ERROR:    evt_new.errors   = evt_q.errors + 64'd1;
      cbs_pkg::CMD_READ_BIN: begin
        out_sums_d  = bin_cur;
        out_total_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (pop) state_d = S_EXEC;
      S_EXEC:  if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign op_pop_o      = pop;
  assign ram_rd_en_o   = pop;
  assign ram_rd_addr_o = bin_i;
  assign ram_wr_en_o   = fire && is_add;
  assign ram_wr_addr_o = bin_q;
  assign ram_wdata_o   = bin_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bin_valid_q <= '0;
      tot_q       <= '0;
      evt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        evt_q       <= evt_new;
        out_valid_q <= 1'b1;
        if (is_add) begin
          tot_q              <= tot_new;
          bin_valid_q[bin_q] <= 1'b1;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q  <= op_i;
      bin_q <= bin_i;
    end
    if (fire) begin
      out_sums_q  <= out_sums_d;
      out_evt_q   <= evt_new;
      out_total_q <= out_total_d;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.block_count          = out_sums_q.blocks;
  assign out_o.logical_sum          = out_sums_q.logical;
  assign out_o.physical_sum         = out_sums_q.physical;
  assign out_o.allocated_sum        = out_sums_q.allocated;
  assign out_o.embedded_count       = out_sums_q.emb_blocks;
  assign out_o.embedded_logical_sum = out_sums_q.emb_logical;
  assign out_o.hole_count           = out_evt_q.holes;
  assign out_o.redacted_count       = out_evt_q.redacted;
  assign out_o.error_count          = out_evt_q.errors;
  assign out_o.unknown_count        = out_evt_q.unknown;
  assign out_o.record_is_total      = out_total_q;

endmodule

// ===== design/cbs_checker.sv =====
`include "assert_macros.svh"

module cbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // no result pending while reset is held
  `CBS_ASSERT(a_reset_out_empty, clk_i, !rst_ni |=> !out_valid_i)
  // queue is empty after reset, so the input side is open
  `CBS_ASSERT(a_reset_in_open, clk_i, !rst_ni |=> in_ready_i)
  // the queue only fills through a word taken on the previous edge
  `CBS_ASSERT_RST(a_full_after_take, clk_i, rst_ni, $fell(in_ready_i) |-> $past(in_valid_i))
  `CBS_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

endmodule

bind compression_bin_statistics cbs_checker u_cbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
